[design/bis_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bis_pkg
// shared types and constants of the interpolation search core
// ----------------------------------------------------------------------------
package bis_pkg;

  localparam int TABLE_DEPTH = 1024;
  localparam int ADDR_W      = $clog2(TABLE_DEPTH);
  localparam int CNT_W       = 11;
  localparam int KEY_W       = 32;
  localparam int VOL_W       = 31;
  localparam int Q_FRAC      = 16;
  localparam int NUM_W       = 44;
  localparam int DEN_W       = 34;
  localparam int ROOT_W      = 22;
  localparam int ACC_W       = 32;

  localparam logic OP_LOAD   = 1'b0;
  localparam logic OP_SEARCH = 1'b1;

  typedef struct packed {
    logic                    op;
    logic [ADDR_W-1:0]       entry_index;
    logic signed [KEY_W-1:0] day_key;
    logic [VOL_W-1:0]        entry_volume;
  } in_t;

  typedef struct packed {
    logic             found;
    logic [VOL_W-1:0] result_volume;
  } out_t;

endpackage

[design/bis_div.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bis_div
// bit-serial signed floor divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module bis_div (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  input  logic signed [bis_pkg::NUM_W-1:0] num,
  input  logic signed [bis_pkg::DEN_W-1:0] den,
  output logic                             done,
  output logic signed [bis_pkg::NUM_W-1:0] quo
);

  localparam int MW = bis_pkg::NUM_W - 1;
  localparam int DW = bis_pkg::DEN_W - 1;

  logic          busy_r, busy_nxt;
  logic          done_r, done_nxt;
  logic [5:0]    cnt_r, cnt_nxt;
  logic [MW-1:0] qm_r, qm_nxt;
  logic [DW-1:0] rem_r, rem_nxt;
  logic [DW-1:0] dm_r, dm_nxt;
  logic          neg_r, neg_nxt;

  logic [bis_pkg::NUM_W-1:0] nmag;
  logic [bis_pkg::DEN_W-1:0] dmag;
  logic [DW:0]               sh;
  logic [bis_pkg::NUM_W-1:0] qt;

  always_comb begin
    nmag     = num[bis_pkg::NUM_W-1] ? -num : num;
    dmag     = den[bis_pkg::DEN_W-1] ? -den : den;
    sh       = {rem_r, qm_r[MW-1]};
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    qm_nxt   = qm_r;
    rem_nxt  = rem_r;
    dm_nxt   = dm_r;
    neg_nxt  = neg_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = 6'(MW);
      qm_nxt   = nmag[MW-1:0];
      rem_nxt  = '0;
      dm_nxt   = dmag[DW-1:0];
      neg_nxt  = num[bis_pkg::NUM_W-1] ^ den[bis_pkg::DEN_W-1];
    end else if (busy_r) begin
      if (sh >= {1'b0, dm_r}) begin
        rem_nxt = DW'(sh - {1'b0, dm_r});
        qm_nxt  = {qm_r[MW-2:0], 1'b1};
      end else begin
        rem_nxt = sh[DW-1:0];
        qm_nxt  = {qm_r[MW-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 6'd1;
      if (cnt_r == 6'd1) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
    qt = {1'b0, qm_r};
    if (neg_r) begin
      quo = -$signed(qt) - ((rem_r != '0) ? 44'sd1 : 44'sd0);
    end else begin
      quo = $signed(qt);
    end
  end

  assign done = done_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    qm_r  <= qm_nxt;
    rem_r <= rem_nxt;
    dm_r  <= dm_nxt;
    neg_r <= neg_nxt;
  end

endmodule

[design/bis_sqrt.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bis_sqrt
// digit-by-digit square root of size, result in unsigned q6.16, truncated
// ----------------------------------------------------------------------------
module bis_sqrt (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  input  logic [bis_pkg::CNT_W-1:0]         size,
  output logic                              done,
  output logic [bis_pkg::ROOT_W-1:0]        root
);

  localparam int XW = bis_pkg::CNT_W + 2 * bis_pkg::Q_FRAC;

  logic          busy_r, busy_nxt;
  logic          done_r, done_nxt;
  logic [XW-1:0] x_r, x_nxt;
  logic [XW-1:0] r_r, r_nxt;
  logic [XW-1:0] b_r, b_nxt;
  logic [XW-1:0] t;

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    x_nxt    = x_r;
    r_nxt    = r_r;
    b_nxt    = b_r;
    t        = r_r + b_r;
    if (start) begin
      busy_nxt = 1'b1;
      x_nxt    = {size, {(2 * bis_pkg::Q_FRAC){1'b0}}};
      r_nxt    = '0;
      b_nxt    = {1'b1, {(XW-1){1'b0}}} >> ((XW - 1) % 2);
    end else if (busy_r) begin
      if (x_r >= t) begin
        x_nxt = x_r - t;
        r_nxt = (r_r >> 1) + b_r;
      end else begin
        r_nxt = r_r >> 1;
      end
      b_nxt = b_r >> 2;
      if (b_r[0]) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  assign done = done_r;
  assign root = r_r[bis_pkg::ROOT_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    x_r <= x_nxt;
    r_r <= r_nxt;
    b_r <= b_nxt;
  end

endmodule

[design/binary_interpolation_search_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// binary_interpolation_search_core
// table of ordered day keys with volumes, searched by interpolation and jumps
// ----------------------------------------------------------------------------
// load transaction: no result
// search transaction: a zero count gives a miss without a table read; one entry or a key out of
//   range is settled by the first and last entries; otherwise interpolation (the divider skipped
//   with a zero divisor), square root with its probe compare, jumps, bound updates and scanned entries
// one transaction in flight at a time, the next accepted at the edge that takes its result
// synchronous reset, table contents kept
// ----------------------------------------------------------------------------
module binary_interpolation_search_core (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  bis_pkg::in_t                      in_data,
  output logic                              out_valid,
  input  logic                              out_stall,
  output bis_pkg::out_t                     out_data,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [bis_pkg::CNT_W-1:0]         cfg_entry_count
);

  localparam int AW = bis_pkg::ADDR_W;
  localparam int CW = bis_pkg::CNT_W;
  localparam int IW = bis_pkg::ACC_W - bis_pkg::Q_FRAC + 1;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_RD0  = 4'd1;
  localparam logic [3:0] S_RDL  = 4'd2;
  localparam logic [3:0] S_DVS  = 4'd3;
  localparam logic [3:0] S_DVW  = 4'd4;
  localparam logic [3:0] S_CMP  = 4'd5;
  localparam logic [3:0] S_SCAN = 4'd6;
  localparam logic [3:0] S_SQW  = 4'd7;
  localparam logic [3:0] S_JMP  = 4'd8;
  localparam logic [3:0] S_JRD  = 4'd9;
  localparam logic [3:0] S_BND  = 4'd10;
  localparam logic [3:0] S_RLF  = 4'd11;
  localparam logic [3:0] S_RRT  = 4'd12;

  logic [bis_pkg::KEY_W+bis_pkg::VOL_W-1:0] mem [bis_pkg::TABLE_DEPTH];
  logic [bis_pkg::KEY_W+bis_pkg::VOL_W-1:0] rd_r;
  logic [AW-1:0]                            mem_addr;
  logic                                     mem_we;
  logic signed [bis_pkg::KEY_W-1:0]         rd_key;
  logic [bis_pkg::VOL_W-1:0]                rd_vol;

  logic [3:0]                       state_r, state_nxt;
  logic [CW-1:0]                    count_r, count_nxt;
  logic                             out_valid_r, out_valid_nxt;
  bis_pkg::out_t                    out_data_r, out_data_nxt;
  logic signed [bis_pkg::KEY_W-1:0] key_r, key_nxt;
  logic signed [bis_pkg::KEY_W-1:0] klo_r, klo_nxt;
  logic [bis_pkg::VOL_W-1:0]        v0_r, v0_nxt;
  logic [CW-1:0]                    n_r, n_nxt;
  logic [CW-1:0]                    size_r, size_nxt;
  logic [AW-1:0]                    left_r, left_nxt;
  logic [AW-1:0]                    right_r, right_nxt;
  logic [AW-1:0]                    next_r, next_nxt;
  logic [1:0]                       k_r, k_nxt;
  logic                             up_r, up_nxt;
  logic                             ceil_r, ceil_nxt;
  logic signed [bis_pkg::NUM_W-1:0] num_r, num_nxt;
  logic signed [bis_pkg::DEN_W-1:0] den_r, den_nxt;
  logic [bis_pkg::ROOT_W-1:0]       s_r, s_nxt;
  logic signed [bis_pkg::ACC_W-1:0] acc_r, acc_nxt;

  logic                             div_start, div_done;
  logic                             sq_start, sq_done;
  logic signed [bis_pkg::NUM_W-1:0] div_quo;
  logic [bis_pkg::ROOT_W-1:0]       sq_root;

  logic                             in_acc;
  logic signed [bis_pkg::ACC_W-1:0] s_ext;
  logic signed [IW-1:0]             idx, idx_a, idx_b;
  logic signed [IW-1:0]             n_ext, nm1_ext;
  logic [AW-1:0]                    rc, lc;
  logic signed [bis_pkg::NUM_W-1:0] qs;
  logic [AW-1:0]                    qc;
  logic [CW-1:0]                    sz_m1;

  function automatic logic signed [IW-1:0] idx_of(input logic signed [bis_pkg::ACC_W-1:0] a);
    logic [bis_pkg::ACC_W-1:0] mag;
    logic [IW-1:0]             q;
    mag = a[bis_pkg::ACC_W-1] ? -a : a;
    q   = {1'b0, mag[bis_pkg::ACC_W-1:bis_pkg::Q_FRAC]};
    return a[bis_pkg::ACC_W-1] ? -$signed(q) : $signed(q);
  endfunction

  function automatic logic signed [bis_pkg::DEN_W-1:0] DW_ext(
    input logic signed [bis_pkg::KEY_W-1:0] v);
    return $signed({{(bis_pkg::DEN_W-bis_pkg::KEY_W){v[bis_pkg::KEY_W-1]}}, v});
  endfunction

  assign rd_key = rd_r[bis_pkg::KEY_W+bis_pkg::VOL_W-1:bis_pkg::VOL_W];
  assign rd_vol = rd_r[bis_pkg::VOL_W-1:0];

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[in_data.entry_index] <= {in_data.day_key, in_data.entry_volume};
    end
    rd_r <= mem[mem_addr];
  end

  bis_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (num_r),
    .den   (den_r),
    .done  (div_done),
    .quo   (div_quo)
  );

  bis_sqrt u_sqrt (
    .clk   (clk),
    .rst_n (rst_n),
    .start (sq_start),
    .size  (size_r),
    .done  (sq_done),
    .root  (sq_root)
  );

  assign in_stall  = (state_r != S_IDLE) || (out_valid_r && out_stall);
  assign in_acc    = in_valid && !in_stall;
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = cfg_valid ? cfg_entry_count : count_r;
    out_valid_nxt = (out_valid_r && out_stall) ? 1'b1 : 1'b0;
    out_data_nxt  = out_data_r;
    key_nxt       = key_r;
    klo_nxt       = klo_r;
    v0_nxt        = v0_r;
    n_nxt         = n_r;
    size_nxt      = size_r;
    left_nxt      = left_r;
    right_nxt     = right_r;
    next_nxt      = next_r;
    k_nxt         = k_r;
    up_nxt        = up_r;
    ceil_nxt      = ceil_r;
    num_nxt       = num_r;
    den_nxt       = den_r;
    s_nxt         = s_r;
    acc_nxt       = acc_r;
    mem_addr      = '0;
    mem_we        = 1'b0;
    div_start     = 1'b0;
    sq_start      = 1'b0;
    s_ext         = $signed({{(bis_pkg::ACC_W-bis_pkg::ROOT_W){1'b0}}, s_r});
    idx           = idx_of(acc_r);
    idx_a         = up_r ? idx_of(acc_r) : idx_of(acc_r + s_ext);
    idx_b         = up_r ? idx_of(acc_r - s_ext) : idx_of(acc_r);
    n_ext         = $signed({{(IW-CW){1'b0}}, n_r});
    nm1_ext       = $signed({{(IW-CW){1'b0}}, CW'(n_r - 1'b1)});
    sz_m1         = size_r - 1'b1;
    qs            = ceil_r ? -div_quo : div_quo;
    if (qs < 0) begin
      qc = '0;
    end else if (qs > $signed({{(bis_pkg::NUM_W-CW){1'b0}}, sz_m1})) begin
      qc = sz_m1[AW-1:0];
    end else begin
      qc = qs[AW-1:0];
    end
    if (idx_a < 0) begin
      rc = '0;
    end else if (idx_a > nm1_ext) begin
      rc = nm1_ext[AW-1:0];
    end else begin
      rc = idx_a[AW-1:0];
    end
    if (idx_b < 0) begin
      lc = '0;
    end else if (idx_b > $signed({{(IW-AW){1'b0}}, rc})) begin
      lc = rc;
    end else begin
      lc = idx_b[AW-1:0];
    end

    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          if (in_data.op == bis_pkg::OP_LOAD) begin
            mem_we = 1'b1;
          end else begin
            key_nxt = in_data.day_key;
            n_nxt   = (count_r > CW'(bis_pkg::TABLE_DEPTH)) ?
                      CW'(bis_pkg::TABLE_DEPTH) : count_r;
            if (count_r == '0) begin
              out_valid_nxt = 1'b1;
              out_data_nxt  = '0;
            end else begin
              state_nxt = S_RD0;
            end
          end
        end
      end
      S_RD0: begin
        klo_nxt   = rd_key;
        v0_nxt    = rd_vol;
        mem_addr  = AW'(n_r - 1'b1);
        state_nxt = S_RDL;
      end
      S_RDL: begin
        if (key_r < klo_r || key_r > rd_key) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = '0;
          state_nxt     = S_IDLE;
        end else if (n_r == CW'(1)) begin
          out_valid_nxt              = 1'b1;
          out_data_nxt.found         = (key_r == klo_r);
          out_data_nxt.result_volume = (key_r == klo_r) ? v0_r : '0;
          state_nxt                  = S_IDLE;
        end else begin
          num_nxt   = $signed({1'b0, CW'(n_r - 1'b1)}) *
                      ($signed({key_r[bis_pkg::KEY_W-1], key_r}) -
                       $signed({klo_r[bis_pkg::KEY_W-1], klo_r}));
          num_nxt   = -num_nxt;
          den_nxt   = DW_ext(rd_key) - DW_ext(klo_r);
          ceil_nxt  = 1'b1;
          left_nxt  = '0;
          size_nxt  = n_r;
          state_nxt = S_DVS;
        end
      end
      S_DVS: begin
        if (den_r == '0) begin
          next_nxt  = left_r;
          mem_addr  = left_r;
          state_nxt = S_CMP;
        end else begin
          div_start = 1'b1;
          state_nxt = S_DVW;
        end
      end
      S_DVW: begin
        mem_addr = left_r + qc;
        if (div_done) begin
          next_nxt  = left_r + qc;
          state_nxt = S_CMP;
        end
      end
      S_CMP: begin
        if (rd_key == key_r) begin
          out_valid_nxt              = 1'b1;
          out_data_nxt.found         = 1'b1;
          out_data_nxt.result_volume = rd_vol;
          state_nxt                  = S_IDLE;
        end else if (size_r <= CW'(3)) begin
          mem_addr  = left_r;
          k_nxt     = '0;
          state_nxt = S_SCAN;
        end else begin
          sq_start  = 1'b1;
          up_nxt    = (key_r >= rd_key);
          state_nxt = S_SQW;
        end
      end
      S_SCAN: begin
        if (rd_key == key_r) begin
          out_valid_nxt              = 1'b1;
          out_data_nxt.found         = 1'b1;
          out_data_nxt.result_volume = rd_vol;
          state_nxt                  = S_IDLE;
        end else if (CW'(k_r) + CW'(1) == size_r) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = '0;
          state_nxt     = S_IDLE;
        end else begin
          k_nxt    = k_r + 2'd1;
          mem_addr = left_r + AW'(k_r) + AW'(1);
        end
      end
      S_SQW: begin
        if (sq_done) begin
          s_nxt     = sq_root;
          acc_nxt   = $signed({{(bis_pkg::ACC_W-AW-bis_pkg::Q_FRAC){1'b0}}, next_r,
                               {bis_pkg::Q_FRAC{1'b0}}});
          state_nxt = S_JMP;
        end
      end
      S_JMP: begin
        if ((up_r && idx >= n_ext) || (!up_r && idx < 0)) begin
          state_nxt = S_BND;
        end else begin
          mem_addr  = idx[AW-1:0];
          state_nxt = S_JRD;
        end
      end
      S_JRD: begin
        if (up_r) begin
          if (key_r <= rd_key) begin
            state_nxt = S_BND;
          end else begin
            acc_nxt   = acc_r + s_ext;
            state_nxt = S_JMP;
          end
        end else begin
          if (key_r >= rd_key) begin
            state_nxt = S_BND;
          end else begin
            acc_nxt   = acc_r - s_ext;
            state_nxt = S_JMP;
          end
        end
      end
      S_BND: begin
        right_nxt = rc;
        left_nxt  = lc;
        size_nxt  = CW'(rc) - CW'(lc) + CW'(1);
        mem_addr  = lc;
        state_nxt = S_RLF;
      end
      S_RLF: begin
        klo_nxt   = rd_key;
        mem_addr  = right_r;
        state_nxt = S_RRT;
      end
      S_RRT: begin
        num_nxt   = $signed({1'b0, sz_m1}) *
                    ($signed({key_r[bis_pkg::KEY_W-1], key_r}) -
                     $signed({klo_r[bis_pkg::KEY_W-1], klo_r}));
        den_nxt   = DW_ext(rd_key) - DW_ext(klo_r);
        ceil_nxt  = 1'b0;
        state_nxt = S_DVS;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= CW'(1);
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
    out_data_r <= out_data_nxt;
    key_r      <= key_nxt;
    klo_r      <= klo_nxt;
    v0_r       <= v0_nxt;
    n_r        <= n_nxt;
    size_r     <= size_nxt;
    left_r     <= left_nxt;
    right_r    <= right_nxt;
    next_r     <= next_nxt;
    k_r        <= k_nxt;
    up_r       <= up_nxt;
    ceil_r     <= ceil_nxt;
    num_r      <= num_nxt;
    den_r      <= den_nxt;
    s_r        <= s_nxt;
    acc_r      <= acc_nxt;
  end

endmodule
